// ===== rtl/core/csvqfs_pkg.sv =====
package csvqfs_pkg;

    // Field separator and quote characters
    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] COMMA_CH = 8'h2C;

    // Largest field count supported by the hardware
    localparam int FIELD_LIMIT = 32;

    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 5;
    localparam int TOTAL_W = 6;
    localparam int LIMIT_W = 6;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SPLIT_LIMIT = 1'b0;

    typedef struct packed {
        logic               char_valid;
        logic [CHAR_W-1:0]  char_out;
        logic               field_closed;
        logic [FIELD_W-1:0] field_number;
        logic               line_done;
        logic [TOTAL_W-1:0] field_total;
    } t_result;

endpackage

// ===== rtl/core/csv_quoted_field_splitter.sv =====
// CSV line splitter with quote escaping.
// Input channel: one line byte per transaction on i_char_in, i_last_byte
// flags the final byte; handshake i_valid / o_ready.
// Output channel: one result transaction per input byte (o_valid / i_ready):
// the text byte if any, a field-close mark with its index, and on the final
// byte line_done with the field count. Quotes toggle quoted mode and are
// dropped; a doubled quote inside quotes gives one literal quote.
// Configuration: APB split-limit register at byte address 0 (reset 32).
// The user must write it only while the block is idle; the block does not
// enforce this. pready is always high. A byte is taken into the input
// register, then goes through the parse logic into the result register.
// Throughput: one transaction per cycle while i_ready is high; the parse
// state is seven flops: quote mode, pending quote and the field index.
// Stall: when i_ready is low, the result register holds and one more
// byte waits in the input register; o_ready drops only when both are full.
// Reset (synchronous, active low) empties both registers, clears the
// line state and loads the split limit with 32.
module csv_quoted_field_splitter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [csvqfs_pkg::CHAR_W-1:0]      i_char_in,
    input  logic                               i_last_byte,
    // output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_char_valid,
    output logic [csvqfs_pkg::CHAR_W-1:0]      o_char_out,
    output logic                               o_field_closed,
    output logic [csvqfs_pkg::FIELD_W-1:0]     o_field_number,
    output logic                               o_line_done,
    output logic [csvqfs_pkg::TOTAL_W-1:0]     o_field_total,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // input register
    logic                           r_in_valid;
    logic [csvqfs_pkg::CHAR_W-1:0]  r_in_char;
    logic                           r_in_last;

    // result register
    logic                           r_out_valid;
    csvqfs_pkg::t_result            r_out;

    logic                           w_out_free;
    logic                           w_step;
    logic [csvqfs_pkg::FIELD_W-1:0] w_limit_m1;
    csvqfs_pkg::t_result            w_res;

    // Result slot frees up when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_ready;
    // Byte in the input register moves through the parser into the result slot
    assign w_step     = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_in;
            r_in_last <= i_last_byte;
        end
    end

    csvqfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_limit_m1 (w_limit_m1)
    );

    csvqfs_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .i_limit_m1 (w_limit_m1),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_char_valid   = r_out.char_valid;
    assign o_char_out     = r_out.char_out;
    assign o_field_closed = r_out.field_closed;
    assign o_field_number = r_out.field_number;
    assign o_line_done    = r_out.line_done;
    assign o_field_total  = r_out.field_total;

endmodule

// ===== rtl/core/csvqfs_cfg.sv =====
module csvqfs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [csvqfs_pkg::FIELD_W-1:0]     o_limit_m1
);

    logic [csvqfs_pkg::LIMIT_W-1:0] r_split_limit;
    logic [csvqfs_pkg::LIMIT_W-1:0] w_limit;
    logic                           w_sel_max;

    assign pready    = 1'b1;
    assign w_sel_max = (paddr[2] == csvqfs_pkg::REG_SPLIT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_limit <= csvqfs_pkg::LIMIT_W'(csvqfs_pkg::FIELD_LIMIT);
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_split_limit <= pwdata[csvqfs_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = w_sel_max ? {{(32-csvqfs_pkg::LIMIT_W){1'b0}}, r_split_limit} : 32'd0;

    // Clamp to 1..FIELD_LIMIT, then hand over limit - 1 (max comma count)
    always_comb begin
        if (r_split_limit == '0) begin
            w_limit = csvqfs_pkg::LIMIT_W'(1);
        end else if (r_split_limit > csvqfs_pkg::LIMIT_W'(csvqfs_pkg::FIELD_LIMIT)) begin
            w_limit = csvqfs_pkg::LIMIT_W'(csvqfs_pkg::FIELD_LIMIT);
        end else begin
            w_limit = r_split_limit;
        end
    end

    assign o_limit_m1 = csvqfs_pkg::FIELD_W'(w_limit - csvqfs_pkg::LIMIT_W'(1));

endmodule

// ===== rtl/core/csvqfs_parse.sv =====
module csvqfs_parse (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic [csvqfs_pkg::CHAR_W-1:0]      i_char,
    input  logic                               i_last,
    input  logic [csvqfs_pkg::FIELD_W-1:0]     i_limit_m1,
    output csvqfs_pkg::t_result                o_res
);

    logic                           r_quoted, n_quoted;
    logic                           r_pending, n_pending;
    logic [csvqfs_pkg::FIELD_W-1:0] r_field, n_field;

    logic w_is_quote;
    logic w_is_comma;
    logic w_quoted_eff;

    assign w_is_quote = (i_char == csvqfs_pkg::QUOTE_CH);
    assign w_is_comma = (i_char == csvqfs_pkg::COMMA_CH);
    // A pending quote followed by a non-quote closes the quoted section first
    assign w_quoted_eff = r_quoted && !r_pending;

    always_comb begin
        n_quoted  = r_quoted;
        n_pending = 1'b0;
        n_field   = r_field;
        o_res              = '0;
        o_res.field_number = r_field;

        if (r_pending && w_is_quote) begin
            // doubled quote: one literal quote
            o_res.char_valid = 1'b1;
            o_res.char_out   = csvqfs_pkg::QUOTE_CH;
        end else begin
            if (r_pending) begin
                n_quoted = 1'b0;
            end
            if (w_is_quote) begin
                if (w_quoted_eff) begin
                    if (i_last) begin
                        n_quoted = 1'b0;
                    end else begin
                        n_pending = 1'b1;
                    end
                end else begin
                    n_quoted = 1'b1;
                end
            end else if (w_is_comma && !w_quoted_eff && (r_field < i_limit_m1)) begin
                o_res.field_closed = 1'b1;
                n_field            = r_field + csvqfs_pkg::FIELD_W'(1);
            end else begin
                o_res.char_valid = 1'b1;
                o_res.char_out   = i_char;
            end
        end

        if (i_last) begin
            o_res.line_done   = 1'b1;
            o_res.field_total = {1'b0, n_field} + csvqfs_pkg::TOTAL_W'(1);
            n_quoted  = 1'b0;
            n_pending = 1'b0;
            n_field   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted  <= 1'b0;
            r_pending <= 1'b0;
            r_field   <= '0;
        end else if (i_step) begin
            r_quoted  <= n_quoted;
            r_pending <= n_pending;
            r_field   <= n_field;
        end
    end

endmodule

// ===== sim/csv_quoted_field_splitter_tb.sv =====
`timescale 1ns / 100ps

// Testbench for csv_quoted_field_splitter.
// A short table of directed bytes runs first at the reset limit. Then come
// random lines under a range of split-limit settings. Every accepted input
// byte goes through a local copy of the splitter state; that result, or the
// hand-typed one of a pinned row, waits in a FIFO. Each result transaction
// is checked, field by field, against the oldest entry of that FIFO.
module csv_quoted_field_splitter_tb;
    import csvqfs_pkg::*;

    localparam int IDLE_LIMIT  = 2000;   // cycles with no transaction at all
    localparam int PHASE_ITEMS = 125;    // at least this many random bytes per configuration phase
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        bit                pinned;      // use the hand-typed result below
        t_result           want;
    } t_stim_row;

    // DUT ports
    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CHAR_W-1:0]   i_char_in;
    logic                i_last_byte;
    logic                o_valid;
    logic                i_ready;
    logic                o_char_valid;
    logic [CHAR_W-1:0]   o_char_out;
    logic                o_field_closed;
    logic [FIELD_W-1:0]  o_field_number;
    logic                o_line_done;
    logic [TOTAL_W-1:0]  o_field_total;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Local copy of the splitter state and its limit register
    logic [LIMIT_W-1:0]  cfg_split_limit;
    bit                  in_quoted_sec;
    bit                  quote_held;
    int                  field_idx;

    // Results due from the DUT, oldest first
    t_result             pending_splits[$];

    // Sideband that travels with the byte on the input channel
    bit                  row_pinned;
    t_result             row_want;

    t_stim_row           stim_rows[$];
    logic [CHAR_W-1:0]   line_bytes[$];

    int                  errors;
    int                  idle_cycles;
    int                  snd_pct;        // chance of a gap after a transaction
    int                  rcv_pct;        // chance of a ready-low burst

    csv_quoted_field_splitter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_in      (i_char_in),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_valid   (o_char_valid),
        .o_char_out     (o_char_out),
        .o_field_closed (o_field_closed),
        .o_field_number (o_field_number),
        .o_line_done    (o_line_done),
        .o_field_total  (o_field_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Splitter state machine: one byte in, one result out
    // ------------------------------------------------------------------
    function automatic t_result split_byte(input logic [CHAR_W-1:0] c, input logic last);
        t_result r;
        int      lim;
        bit      done;
        r    = '0;
        done = 1'b0;
        lim  = int'(cfg_split_limit);
        // out-of-range limits are clamped: 0 means no splitting
        if (lim == 0) lim = 1;
        if (lim > FIELD_LIMIT) lim = FIELD_LIMIT;
        r.field_number = FIELD_W'(field_idx);

        // a quote held from the last byte: doubled quote or end of section
        if (quote_held) begin
            quote_held = 1'b0;
            if (c == QUOTE_CH) begin
                r.char_valid = 1'b1;
                r.char_out   = QUOTE_CH;
                done         = 1'b1;
            end else begin
                in_quoted_sec = 1'b0;
            end
        end

        if (!done) begin
            if (c == QUOTE_CH) begin
                // quote closing on the final byte cannot wait for lookahead
                if (in_quoted_sec) begin
                    if (last) in_quoted_sec = 1'b0;
                    else quote_held = 1'b1;
                end else begin
                    in_quoted_sec = 1'b1;
                end
            end else if (c == COMMA_CH && !in_quoted_sec && field_idx + 1 < lim) begin
                r.field_closed = 1'b1;
                field_idx++;
            end else begin
                r.char_valid = 1'b1;
                r.char_out   = c;
            end
        end

        if (last) begin
            // an open quoted section is simply dropped at end of line
            r.line_done   = 1'b1;
            r.field_total = TOTAL_W'(field_idx + 1);
            in_quoted_sec = 1'b0;
            quote_held    = 1'b0;
            field_idx     = 0;
        end
        return r;
    endfunction

    function automatic void note_error(input string what, input t_result want,
                                       input t_result got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch (%s): exp v=%0b ch=%02h cl=%0b fn=%0d ld=%0b tot=%0d",
                     $realtime, what, want.char_valid, want.char_out, want.field_closed,
                     want.field_number, want.line_done, want.field_total,
                     "\n            act v=%0b ch=%02h cl=%0b fn=%0d ld=%0b tot=%0d",
                     got.char_valid, got.char_out, got.field_closed,
                     got.field_number, got.line_done, got.field_total);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results, then queue the result of any accepted byte.
    // Both channels are sampled at the edge, before the DUT updates.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result nxt;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_char_valid, o_char_out, o_field_closed, o_field_number,
                        o_line_done, o_field_total};
                if (pending_splits.size() == 0) begin
                    note_error("nothing due", '0, got);
                end else begin
                    want = pending_splits.pop_front();
                    if (got.char_valid !== want.char_valid
                            || got.char_out !== want.char_out
                            || got.field_closed !== want.field_closed
                            || got.field_number !== want.field_number
                            || got.line_done !== want.line_done
                            || got.field_total !== want.field_total)
                        note_error("result", want, got);
                end
            end
            if (i_valid && o_ready) begin
                // state advances even for hand-typed rows
                nxt = split_byte(i_char_in, i_last_byte);
                pending_splits.push_back(row_pinned ? row_want : nxt);
            end
        end
    end

    // Watchdog: any transaction, or a register access, counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t timeout, %0d results outstanding", $realtime,
                         pending_splits.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: ready is set low or high at random in bursts, low with chance rcv_pct
    initial begin
        repeat (6) @(posedge i_clk);
        forever begin
            if (rcv_pct != 0 && $urandom_range(99) < rcv_pct) i_ready <= 1'b0;
            else i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks; each is entered and left right after a rising edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last,
                             input bit pinned, input t_result want);
        i_valid     <= 1'b1;
        i_char_in   <= c;
        i_last_byte <= last;
        row_pinned  <= pinned;
        row_want    <= want;
        do @(posedge i_clk); while (!o_ready);
        if (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [CHAR_W-1:0] c, input logic last,
                           input bit pinned, input t_result want);
        t_stim_row row;
        row.ch     = c;
        row.last   = last;
        row.pinned = pinned;
        row.want   = want;
        stim_rows.push_back(row);
    endtask

    // Register writes only happen with nothing in flight; the extra edge lets
    // the monitor queue a byte accepted at the edge this task starts on
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_splits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_read_check(input logic [LIMIT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_SPLIT_LIMIT, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[LIMIT_W-1:0] !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t split limit readback: exp %0d act %0d", $realtime,
                         want, prdata[LIMIT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input logic [LIMIT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SPLIT_LIMIT, 2'b00};
        // upper data bits are noise the register must ignore
        pwdata  <= {(32-LIMIT_W)'($urandom_range(32'h03FF_FFFF)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_split_limit = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        do b = CHAR_W'($urandom_range(255)); while (b == QUOTE_CH || b == COMMA_CH);
        return b;
    endfunction

    // Build one random line into line_bytes
    task automatic make_line();
        int mode;
        int nf;
        int k;
        int pick;
        line_bytes.delete();
        mode = $urandom_range(99);
        if (mode < 60) begin
            // well-formed CSV: plain and quoted fields, escapes and commas inside
            nf = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            for (int f = 0; f < nf; f++) begin
                if (f != 0) line_bytes.push_back(COMMA_CH);
                k = $urandom_range(0, 5);
                if ($urandom_range(1)) begin
                    line_bytes.push_back(QUOTE_CH);
                    for (int j = 0; j < k; j++) begin
                        pick = $urandom_range(9);
                        if (pick < 2) begin
                            line_bytes.push_back(QUOTE_CH);
                            line_bytes.push_back(QUOTE_CH);
                        end else if (pick < 4) begin
                            line_bytes.push_back(COMMA_CH);
                        end else begin
                            line_bytes.push_back(text_byte());
                        end
                    end
                    line_bytes.push_back(QUOTE_CH);
                end else begin
                    for (int j = 0; j < k; j++) line_bytes.push_back(text_byte());
                end
            end
        end else if (mode < 72) begin
            // many separators: can reach field 31 and the split limit
            k = $urandom_range(30, 40);
            for (int j = 0; j < k; j++)
                line_bytes.push_back(($urandom_range(7) == 0) ? text_byte() : COMMA_CH);
        end else begin
            // noise, rich in quotes and commas
            k = $urandom_range(1, 20);
            for (int j = 0; j < k; j++) begin
                pick = $urandom_range(3);
                if (pick == 0) line_bytes.push_back(QUOTE_CH);
                else if (pick == 1) line_bytes.push_back(COMMA_CH);
                else line_bytes.push_back(CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [LIMIT_W-1:0] settings[8];
        int                 sent;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_char_in       = '0;
        i_last_byte     = 1'b0;
        i_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        row_pinned      = 1'b0;
        row_want        = '0;
        errors          = 0;
        idle_cycles     = 0;
        snd_pct         = 20;
        rcv_pct         = 20;
        cfg_split_limit = LIMIT_W'(FIELD_LIMIT);
        in_quoted_sec   = 1'b0;
        quote_held      = 1'b0;
        field_idx       = 0;

        // low extremes first, out-of-range values next, then mid values and the reset value again
        settings = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd33, 6'd5,
                     LIMIT_W'($urandom_range(3, 31)), 6'd32};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_read_check(LIMIT_W'(FIELD_LIMIT));

        // Directed table at the reset limit of 32 fields.
        // Line: a,"x""," , <00> <FF>
        add_row(8'h61, 1'b0, 1, '{1'b1, 8'h61, 1'b0, 5'd0, 1'b0, 6'd0});
        add_row(COMMA_CH, 1'b0, 1, '{1'b0, 8'h00, 1'b1, 5'd0, 1'b0, 6'd0});
        // opening quote is dropped
        add_row(QUOTE_CH, 1'b0, 1, '{1'b0, 8'h00, 1'b0, 5'd1, 1'b0, 6'd0});
        add_row(8'h78, 1'b0, 0, '0);
        add_row(QUOTE_CH, 1'b0, 0, '0);          // held for lookahead
        add_row(QUOTE_CH, 1'b0, 0, '0);          // doubled: literal quote
        add_row(COMMA_CH, 1'b0, 0, '0);          // comma inside quotes is text
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(COMMA_CH, 1'b0, 0, '0);          // closes section and field 1
        add_row(8'h00, 1'b0, 1, '{1'b1, 8'h00, 1'b0, 5'd2, 1'b0, 6'd0});
        add_row(8'hFF, 1'b1, 1, '{1'b1, 8'hFF, 1'b0, 5'd2, 1'b1, 6'd3});
        // quote on the final byte inside quotes closes the section
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(8'h71, 1'b0, 0, '0);
        add_row(QUOTE_CH, 1'b1, 1, '{1'b0, 8'h00, 1'b0, 5'd0, 1'b1, 6'd1});
        // held quote resolved by the final byte
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(8'h7A, 1'b1, 0, '0);
        // held quote followed by a quote on the final byte
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(QUOTE_CH, 1'b1, 0, '0);
        // line ends inside an open quoted section
        add_row(QUOTE_CH, 1'b0, 0, '0);
        add_row(COMMA_CH, 1'b0, 0, '0);
        add_row(8'h6B, 1'b1, 0, '0);
        // one-byte line that is a separator: two empty fields
        add_row(COMMA_CH, 1'b1, 1, '{1'b0, 8'h00, 1'b1, 5'd0, 1'b1, 6'd2});

        foreach (stim_rows[i])
            send_byte(stim_rows[i].ch, stim_rows[i].last, stim_rows[i].pinned,
                      stim_rows[i].want);

        // Random lines, one limit setting per phase
        foreach (settings[p]) begin
            wait_idle();
            reg_write(settings[p]);
            reg_read_check(settings[p]);
            if (p == 7) begin
                // final stretch runs flat out
                snd_pct = 0;
                rcv_pct = 0;
            end else if (p == 3) begin
                snd_pct = 0;
                rcv_pct = 50;
            end else begin
                snd_pct = $urandom_range(5, 40);
                rcv_pct = $urandom_range(5, 40);
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                make_line();
                foreach (line_bytes[j])
                    send_byte(line_bytes[j], j == line_bytes.size() - 1, 0, '0);
                sent += line_bytes.size();
            end
        end

        // Drain, then keep the clock running so that stray results would show
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_splits.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0 && pending_splits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
